[hdl/dead_reckoning_position_update_assert.svh]
// assertion macros for the dead reckoning position update rtl
// expects clk and rst in the scope of each use
`ifndef DEAD_RECKONING_POSITION_UPDATE_ASSERT_SVH
`define DEAD_RECKONING_POSITION_UPDATE_ASSERT_SVH

// same-cycle implication
`define DRPU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DRPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/drpu_pkg.sv]
// types, constants and helper functions for the dead reckoning position update
// no dependencies
package drpu_pkg;

  // heading reduction, centidegrees
  localparam logic [15:0] CDEG_FULL    = 16'd36000;
  localparam logic [15:0] CDEG_QUARTER = 16'd9000;
  localparam logic [15:0] CDEG_HALF    = 16'd18000;
  localparam logic [15:0] CDEG_3QUART  = 16'd27000;
  localparam int          REM_W        = 14;

  // centidegrees to radians in q2.30, and cordic start vector
  localparam logic [31:0]        CDEG_TO_Q30     = 32'd187403;
  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  // cordic iteration count and counter sizing
  localparam int               TRIG_ITERATIONS = 16;
  localparam int               ITER_W          = $clog2(TRIG_ITERATIONS);
  localparam logic [ITER_W-1:0] ITER_LAST      = ITER_W'(TRIG_ITERATIONS - 1);
  localparam int               ATAN_IDX_W      = 5;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int                   CFG_INDEX_W = 1;
  localparam int                   CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y = 1'd1;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // one classified item in the queue
  typedef struct packed {
    quad_t              quad;
    logic signed [31:0] z;
    logic signed [32:0] delta;
  } item_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_wr_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_TRIG = 5'b00100,
    S_MUL  = 5'b01000,
    S_ACC  = 5'b10000
  } back_state_t;

  // truncated arctangent table, q2.30
  function automatic logic signed [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:    v = 32'sh3243F6A8;
      5'd1:    v = 32'sh1DAC6705;
      5'd2:    v = 32'sh0FADBAFC;
      5'd3:    v = 32'sh07F56EA6;
      5'd4:    v = 32'sh03FEAB76;
      5'd5:    v = 32'sh01FFD55B;
      5'd6:    v = 32'sh00FFFAAA;
      5'd7:    v = 32'sh007FFF55;
      5'd8:    v = 32'sh003FFFEA;
      5'd9:    v = 32'sh001FFFFD;
      5'd10:   v = 32'sh000FFFFF;
      5'd11:   v = 32'sh0007FFFF;
      5'd12:   v = 32'sh0003FFFF;
      5'd13:   v = 32'sh0001FFFF;
      5'd14:   v = 32'sh0000FFFF;
      5'd15:   v = 32'sh00007FFF;
      5'd16:   v = 32'sh00003FFF;
      5'd17:   v = 32'sh00001FFF;
      5'd18:   v = 32'sh00000FFF;
      5'd19:   v = 32'sh000007FF;
      5'd20:   v = 32'sh000003FF;
      5'd21:   v = 32'sh000001FF;
      5'd22:   v = 32'sh000000FF;
      5'd23:   v = 32'sh0000007F;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // q2.30 to q1.15, round half up, saturate; 17 bits so negation stays exact
  function automatic logic signed [16:0] to_q15(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [17:0] sh;
    logic signed [16:0] r;
    t  = {v[31], v} + 33'sd16384;
    sh = t[32:15];
    if (sh > 18'sd32767) begin
      r = 17'sd32767;
    end else if (sh < -18'sd32768) begin
      r = -17'sd32768;
    end else begin
      r = sh[16:0];
    end
    return r;
  endfunction

  // position plus rounded change, saturated to signed 32 bits
  function automatic logic signed [31:0] acc_sat(input logic signed [31:0] pos,
                                                 input logic signed [49:0] prod);
    logic signed [49:0] rnd;
    logic signed [34:0] chg;
    logic signed [35:0] sum;
    logic signed [31:0] r;
    rnd = prod + 50'sd16384;
    chg = rnd[49:15];
    sum = 36'(pos) + 36'(chg);
    if (sum > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (sum < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = sum[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/drpu_chan_if.sv]
// valid/ready channel interfaces for samples in and positions out
// payload types follow drpu_pkg field widths
interface drpu_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        heading_cdeg;
  logic signed [31:0] odom_total;

  modport source(output valid, heading_cdeg, odom_total, input ready);
  modport sink(input valid, heading_cdeg, odom_total, output ready);
endinterface

interface drpu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;

  modport source(output valid, pos_x_out, pos_y_out, input ready);
  modport sink(input valid, pos_x_out, pos_y_out, output ready);
endinterface

[hdl/drpu_front.sv]
// front end: takes samples, reduces heading, forms distance delta and cordic angle
// depends on drpu_pkg and drpu_chan_if
module drpu_front (
  input  logic              clk,
  input  logic              rst,
  drpu_in_if.sink           in_ch,
  output drpu_pkg::item_t   push_item,
  output logic              push_valid,
  input  logic              push_ready
);

  logic                           s1_valid;
  drpu_pkg::quad_t                s1_quad;
  logic [drpu_pkg::REM_W-1:0]     s1_rem;
  logic signed [32:0]             s1_delta;
  logic signed [31:0]             last_odom;

  logic [15:0]                    h_mod;
  logic [15:0]                    rem_full;
  drpu_pkg::quad_t                quad;
  logic signed [32:0]             delta;
  logic [31:0]                    z_prod;
  logic                           take;

  assign in_ch.ready = !s1_valid || push_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // heading modulo a full turn, then quadrant and remainder
  always_comb begin
    h_mod = (in_ch.heading_cdeg >= drpu_pkg::CDEG_FULL) ?
            in_ch.heading_cdeg - drpu_pkg::CDEG_FULL : in_ch.heading_cdeg;
    if (h_mod >= drpu_pkg::CDEG_3QUART) begin
      quad     = drpu_pkg::QUAD_3;
      rem_full = h_mod - drpu_pkg::CDEG_3QUART;
    end else if (h_mod >= drpu_pkg::CDEG_HALF) begin
      quad     = drpu_pkg::QUAD_2;
      rem_full = h_mod - drpu_pkg::CDEG_HALF;
    end else if (h_mod >= drpu_pkg::CDEG_QUARTER) begin
      quad     = drpu_pkg::QUAD_1;
      rem_full = h_mod - drpu_pkg::CDEG_QUARTER;
    end else begin
      quad     = drpu_pkg::QUAD_0;
      rem_full = h_mod;
    end
  end

  assign delta = {in_ch.odom_total[31], in_ch.odom_total} - {last_odom[31], last_odom};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      last_odom <= '0;
    end else begin
      if (take) begin
        s1_valid  <= 1'b1;
        last_odom <= in_ch.odom_total;
      end else if (push_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_quad  <= quad;
      s1_rem   <= rem_full[drpu_pkg::REM_W-1:0];
      s1_delta <= delta;
    end
  end

  // angle in q2.30; registered by the queue
  assign z_prod = {{(32 - drpu_pkg::REM_W){1'b0}}, s1_rem} * drpu_pkg::CDEG_TO_Q30;

  assign push_valid      = s1_valid;
  assign push_item.quad  = s1_quad;
  assign push_item.z     = signed'(z_prod);
  assign push_item.delta = s1_delta;

endmodule

[hdl/drpu_queue.sv]
// small fifo of classified items between front and back
// depends on drpu_pkg
module drpu_queue (
  input  logic              clk,
  input  logic              rst,
  input  drpu_pkg::item_t   push_item,
  input  logic              push_valid,
  output logic              push_ready,
  output drpu_pkg::item_t   pop_item,
  output logic              pop_valid,
  input  logic              pop_ready
);

  drpu_pkg::item_t                entries [drpu_pkg::QUEUE_DEPTH];
  logic [drpu_pkg::QPTR_W-1:0]    wr_ptr;
  logic [drpu_pkg::QPTR_W-1:0]    rd_ptr;
  logic [drpu_pkg::QCNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (count != drpu_pkg::QCNT_W'(drpu_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == drpu_pkg::QPTR_W'(drpu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == drpu_pkg::QPTR_W'(drpu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[hdl/drpu_back.sv]
// back end: iterative cordic, delta scaling, saturating position update, output register
// depends on drpu_pkg, drpu_chan_if and the assertion macro header
`include "dead_reckoning_position_update_assert.svh"

module drpu_back (
  input  logic              clk,
  input  logic              rst,
  input  drpu_pkg::item_t   pop_item,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  drpu_pkg::cfg_wr_t cfg,
  drpu_out_if.source        out_ch
);

  drpu_pkg::back_state_t          state;
  logic [drpu_pkg::ITER_W-1:0]    iter;
  logic signed [31:0]             cx;
  logic signed [31:0]             cy;
  logic signed [31:0]             cz;
  drpu_pkg::quad_t                quad;
  logic signed [32:0]             delta;
  logic signed [16:0]             sn;
  logic signed [16:0]             cs;
  logic signed [49:0]             prod_x;
  logic signed [49:0]             prod_y;
  logic signed [31:0]             pos_x;
  logic signed [31:0]             pos_y;
  logic                           out_valid;
  logic signed [31:0]             out_x;
  logic signed [31:0]             out_y;

  logic signed [31:0]             dx;
  logic signed [31:0]             dy;
  logic signed [31:0]             at;
  logic signed [31:0]             cx_next;
  logic signed [31:0]             cy_next;
  logic signed [31:0]             cz_next;
  logic signed [16:0]             s_q;
  logic signed [16:0]             c_q;
  logic signed [16:0]             sn_next;
  logic signed [16:0]             cs_next;
  logic signed [31:0]             pos_x_next;
  logic signed [31:0]             pos_y_next;
  logic                           out_free;

  assign pop_ready = (state == drpu_pkg::S_IDLE);
  assign out_free  = !out_valid || out_ch.ready;

  // one micro-rotation
  always_comb begin
    dx = cy >>> iter;
    dy = cx >>> iter;
    at = drpu_pkg::atan_q30(drpu_pkg::ATAN_IDX_W'(iter));
    if (!cz[31]) begin
      cx_next = cx - dx;
      cy_next = cy + dy;
      cz_next = cz - at;
    end else begin
      cx_next = cx + dx;
      cy_next = cy - dy;
      cz_next = cz + at;
    end
  end

  // round to q1.15 and fold the quadrant back in
  always_comb begin
    s_q = drpu_pkg::to_q15(cy);
    c_q = drpu_pkg::to_q15(cx);
    case (quad)
      drpu_pkg::QUAD_0: begin sn_next = s_q;  cs_next = c_q;  end
      drpu_pkg::QUAD_1: begin sn_next = c_q;  cs_next = -s_q; end
      drpu_pkg::QUAD_2: begin sn_next = -s_q; cs_next = -c_q; end
      drpu_pkg::QUAD_3: begin sn_next = -c_q; cs_next = s_q;  end
      default:          begin sn_next = s_q;  cs_next = c_q;  end
    endcase
  end

  assign pos_x_next = drpu_pkg::acc_sat(pos_x, prod_x);
  assign pos_y_next = drpu_pkg::acc_sat(pos_y, prod_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= drpu_pkg::S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        drpu_pkg::S_IDLE: begin
          if (pop_valid) begin
            iter  <= '0;
            state <= drpu_pkg::S_ROT;
          end
        end
        drpu_pkg::S_ROT: begin
          iter <= iter + 1'b1;
          if (iter == drpu_pkg::ITER_LAST) begin
            state <= drpu_pkg::S_TRIG;
          end
        end
        drpu_pkg::S_TRIG: begin
          state <= drpu_pkg::S_MUL;
        end
        drpu_pkg::S_MUL: begin
          state <= drpu_pkg::S_ACC;
        end
        drpu_pkg::S_ACC: begin
          if (out_free) begin
            pos_x     <= pos_x_next;
            pos_y     <= pos_y_next;
            out_valid <= 1'b1;
            state     <= drpu_pkg::S_IDLE;
          end
        end
        default: begin
          state <= drpu_pkg::S_IDLE;
        end
      endcase
      // start position loads, for the user to make only while idle; the block does not enforce it
      if (cfg.we && cfg.index == drpu_pkg::REG_START_X) begin
        pos_x <= signed'(cfg.data);
      end
      if (cfg.we && cfg.index == drpu_pkg::REG_START_Y) begin
        pos_y <= signed'(cfg.data);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      drpu_pkg::S_IDLE: begin
        cx    <= drpu_pkg::CORDIC_GAIN_Q30;
        cy    <= '0;
        cz    <= pop_item.z;
        quad  <= pop_item.quad;
        delta <= pop_item.delta;
      end
      drpu_pkg::S_ROT: begin
        cx <= cx_next;
        cy <= cy_next;
        cz <= cz_next;
      end
      drpu_pkg::S_TRIG: begin
        sn <= sn_next;
        cs <= cs_next;
      end
      drpu_pkg::S_MUL: begin
        prod_x <= 50'(delta) * 50'(sn);
        prod_y <= 50'(delta) * 50'(cs);
      end
      drpu_pkg::S_ACC: begin
        if (out_free) begin
          out_x <= pos_x_next;
          out_y <= pos_y_next;
        end
      end
      default: begin
        cz <= cz;
      end
    endcase
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.pos_x_out = out_x;
  assign out_ch.pos_y_out = out_y;

  `DRPU_ASSERT_NEXT(a_rot_step, state == drpu_pkg::S_ROT && iter != drpu_pkg::ITER_LAST, state == drpu_pkg::S_ROT && iter == $past(iter) + 1'b1, "cordic iteration skipped")
  `DRPU_ASSERT_NEXT(a_rot_end, state == drpu_pkg::S_ROT && iter == drpu_pkg::ITER_LAST, state == drpu_pkg::S_TRIG, "cordic did not finish after last iteration")
  `DRPU_ASSERT_NEXT(a_acc_hold, state == drpu_pkg::S_ACC && out_valid && !out_ch.ready && !cfg.we, state == drpu_pkg::S_ACC && $stable(pos_x) && $stable(pos_y), "position updated while result pending")
  `DRPU_ASSERT_NEXT(a_acc_done, state == drpu_pkg::S_ACC && (!out_valid || out_ch.ready), out_valid && state == drpu_pkg::S_IDLE, "result not presented after update")

endmodule

[hdl/dead_reckoning_position_update.sv]
// top level of the dead reckoning position update
// depends on drpu_pkg, drpu_chan_if, drpu_front, drpu_queue and drpu_back
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      heading_cdeg[15:0], odom_total[31:0]
//   out_ch    out   valid/ready      pos_x_out[31:0], pos_y_out[31:0]
//   cfg       in    cfg_we only      cfg_index[0], cfg_data[31:0]
//
// in the back end a sample steps through the idle, rot, trig, mul and acc states;
//   the rot state uses the shared cordic stage, one micro-rotation per cycle
// the front end and a two-entry queue keep taking samples while the cordic runs
// a stalled output holds the back end in its update step; the queue then fills and
//   in_ch.ready drops
// rst is synchronous: positions and last odometer reading clear to zero
module dead_reckoning_position_update (
  input  logic                                 clk,
  input  logic                                 rst,
  drpu_in_if.sink                              in_ch,
  drpu_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [drpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [drpu_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // front to queue
  drpu_pkg::item_t   push_item;
  logic              push_valid;
  logic              push_ready;

  // queue to back
  drpu_pkg::item_t   pop_item;
  logic              pop_valid;
  logic              pop_ready;

  // start position writes, loaded straight into the position registers
  drpu_pkg::cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // heading reduction, distance delta and angle scaling
  drpu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // decouples sample intake from the cordic
  drpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // cordic, scaling and saturating accumulate, one transaction at a time
  drpu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

endmodule
